@@ rtl/mxn_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mxn_pkg: shared types and constants of the mutual exclusion node
// Node count, field widths, event and message codes, and the need set builder.
// ----------------------------------------------------------------------------
package mxn_pkg;

  localparam int NODES    = 32;
  localparam int IDX_W    = $clog2(NODES);
  localparam int CNT_W    = $clog2(NODES + 1);
  localparam int NODE_W   = 6;
  localparam int NCOUNT_W = 7;
  localparam int STAMP_W  = 32;
  localparam int GRANT_W  = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int CQ_DEPTH = 4;
  localparam int CQ_PTR_W = $clog2(CQ_DEPTH);

  localparam logic [STAMP_W-1:0]  CLOCK_MAX = '1;
  localparam logic [GRANT_W-1:0]  GRANT_MAX = '1;
  localparam logic [NODE_W-1:0]   MY_NODE_RESET = '0;
  localparam logic [NCOUNT_W-1:0] NODE_COUNT_RESET = NCOUNT_W'(2);

  typedef enum logic [1:0] {
    OP_REQ  = 2'd0,
    OP_PERM = 2'd1,
    OP_WISH = 2'd2,
    OP_EXIT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_REQ   = 2'd0,
    KIND_PERM  = 2'd1,
    KIND_ENTER = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MY_NODE    = 2'd0,
    REG_NODE_COUNT = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_WALK,
    ENG_REQ2
  } eng_state_t;

  typedef struct packed {
    logic [NODE_W-1:0]   my_node;
    logic [NCOUNT_W-1:0] node_count;
    logic                rebuild;
  } cfg_t;

  typedef struct packed {
    op_t                op;
    logic [IDX_W-1:0]   sender;
    logic [STAMP_W-1:0] stamp;
    logic [STAMP_W-1:0] stamp_next;
  } cmd_t;

  typedef struct packed {
    kind_t              kind;
    logic [NODE_W-1:0]  dest;
    logic [STAMP_W-1:0] req_clock;
    logic               last;
  } res_t;

  // Count clamped to 1..NODES.
  function automatic logic [NCOUNT_W-1:0] eff_count(input logic [NCOUNT_W-1:0] cnt);
    logic [NCOUNT_W-1:0] e;
    e = cnt;
    if (cnt > NCOUNT_W'(NODES)) e = NCOUNT_W'(NODES);
    if (cnt == '0) e = NCOUNT_W'(1);
    return e;
  endfunction

  // Every node below the effective count except this one.
  function automatic logic [NODES-1:0] need_mask(input logic [NODE_W-1:0] me,
                                                 input logic [NCOUNT_W-1:0] cnt);
    logic [NODES-1:0]    m;
    logic [NCOUNT_W-1:0] e;
    e = eff_count(cnt);
    for (int i = 0; i < NODES; i++) begin
      m[i] = (NCOUNT_W'(i) < e) && (NODE_W'(i) != me);
    end
    return m;
  endfunction

  function automatic logic [CNT_W-1:0] need_members(input logic [NODE_W-1:0] me,
                                                    input logic [NCOUNT_W-1:0] cnt);
    logic [NCOUNT_W-1:0] e;
    e = eff_count(cnt);
    if (NCOUNT_W'(me) < e) e = e - NCOUNT_W'(1);
    return CNT_W'(e);
  endfunction

endpackage

@@ rtl/mxn_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mxn_front: event intake and configuration registers
// Accepts events, drops those that can never act, and queues the rest.
// ----------------------------------------------------------------------------
module mxn_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [1:0]                     in_op,
  input  logic [mxn_pkg::NODE_W-1:0]     in_sender,
  input  logic [mxn_pkg::STAMP_W-1:0]    in_stamp,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mxn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mxn_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           q_full,
  output logic                           q_push,
  output mxn_pkg::cmd_t                  q_cmd,
  output mxn_pkg::cfg_t                  cfg
);
  import mxn_pkg::*;

  logic [NODE_W-1:0]   my_node_r, my_node_nxt;
  logic [NCOUNT_W-1:0] node_count_r, node_count_nxt;
  logic                rebuild_r, rebuild_nxt;
  logic                accept, node_ok, sender_ok;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign accept    = in_push && !q_full;

  always_comb begin
    my_node_nxt    = my_node_r;
    node_count_nxt = node_count_r;
    rebuild_nxt    = 1'b0;
    if (cfg_valid) begin
      case (cfg_index)
        REG_MY_NODE: begin
          my_node_nxt = cfg_data[NODE_W-1:0];
          rebuild_nxt = 1'b1;
        end
        REG_NODE_COUNT: begin
          node_count_nxt = cfg_data[NCOUNT_W-1:0];
          rebuild_nxt    = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      my_node_r    <= MY_NODE_RESET;
      node_count_r <= NODE_COUNT_RESET;
      rebuild_r    <= 1'b0;
    end else begin
      my_node_r    <= my_node_nxt;
      node_count_r <= node_count_nxt;
      rebuild_r    <= rebuild_nxt;
    end
  end

  assign cfg = '{my_node: my_node_r, node_count: node_count_r, rebuild: rebuild_r};

  // A node number out of range silences the node; a request from an unknown
  // node or from this node itself is dropped.
  assign node_ok   = (NCOUNT_W'(my_node_r) < NCOUNT_W'(NODES));
  assign sender_ok = (NCOUNT_W'(in_sender) < NCOUNT_W'(NODES)) && (in_sender != my_node_r);

  assign q_push = accept && node_ok && ((op_t'(in_op) != OP_REQ) || sender_ok);

  always_comb begin
    q_cmd.op         = op_t'(in_op);
    q_cmd.sender     = in_sender[IDX_W-1:0];
    q_cmd.stamp      = in_stamp;
    q_cmd.stamp_next = (in_stamp == CLOCK_MAX) ? CLOCK_MAX : in_stamp + STAMP_W'(1);
  end

endmodule

@@ rtl/mxn_cmd_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mxn_cmd_queue: short event queue between intake and engine
// A small flip-flop FIFO of classified events.
// ----------------------------------------------------------------------------
module mxn_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mxn_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output mxn_pkg::cmd_t pop_cmd,
  output logic          empty
);
  import mxn_pkg::*;

  cmd_t                entry_r [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CQ_PTR_W:0]   fill_r, fill_nxt;
  logic                do_push, do_pop;

  assign full    = (fill_r == (CQ_PTR_W+1)'(CQ_DEPTH));
  assign empty   = (fill_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? CQ_PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? CQ_PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push && !do_pop) fill_nxt = (CQ_PTR_W+1)'(fill_r + 1'b1);
    if (do_pop && !do_push) fill_nxt = (CQ_PTR_W+1)'(fill_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ rtl/mxn_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mxn_engine: protocol state and message sequencer
// Applies one event at a time and walks node bitmaps one node per cycle, holding on a set bit while output is full.
// ----------------------------------------------------------------------------
module mxn_engine (
  input  logic          clk,
  input  logic          rst_n,
  input  mxn_pkg::cfg_t cfg,
  input  logic          cmd_avail,
  input  mxn_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          res_valid,
  output mxn_pkg::res_t res,
  input  logic          res_pop
);
  import mxn_pkg::*;

  eng_state_t         state_r, state_nxt;
  logic [STAMP_W-1:0] local_clock_r, local_clock_nxt;
  logic [STAMP_W-1:0] own_stamp_r, own_stamp_nxt;
  logic [GRANT_W-1:0] grant_r, grant_nxt;
  logic [NODES-1:0]   need_r, need_nxt, defer_r, defer_nxt;
  logic [CNT_W-1:0]   need_cnt_r, need_cnt_nxt, defer_cnt_r, defer_cnt_nxt;
  logic               may_wish_r, may_wish_nxt, inside_r, inside_nxt;
  logic [NODES-1:0]   walk_set_r, walk_set_nxt, walk_rest;
  logic [IDX_W-1:0]   walk_idx_r, walk_idx_nxt;
  kind_t              walk_kind_r, walk_kind_nxt;
  logic [IDX_W-1:0]   req_dest_r, req_dest_nxt;
  logic               out_valid_r, out_valid_nxt;
  res_t               out_r, out_nxt;

  logic               out_free, emit, theirs_first;
  res_t               emit_res;
  logic [NODES-1:0]   sbit, walk_bit;
  logic [GRANT_W-1:0] grant_inc;

  assign out_free  = !out_valid_r || res_pop;
  assign sbit      = {{(NODES-1){1'b0}}, 1'b1} << cmd.sender;
  assign walk_bit  = {{(NODES-1){1'b0}}, 1'b1} << walk_idx_r;
  assign walk_rest = walk_set_r & ~walk_bit;
  assign grant_inc = (grant_r == GRANT_MAX) ? grant_r : GRANT_W'(grant_r + 1'b1);
  assign theirs_first = (cmd.stamp < own_stamp_r) ||
                        ((cmd.stamp == own_stamp_r) && (NODE_W'(cmd.sender) < cfg.my_node));

  always_comb begin
    state_nxt       = state_r;
    local_clock_nxt = local_clock_r;
    own_stamp_nxt   = own_stamp_r;
    grant_nxt       = grant_r;
    need_nxt        = need_r;
    need_cnt_nxt    = need_cnt_r;
    defer_nxt       = defer_r;
    defer_cnt_nxt   = defer_cnt_r;
    may_wish_nxt    = may_wish_r;
    inside_nxt      = inside_r;
    walk_set_nxt    = walk_set_r;
    walk_idx_nxt    = walk_idx_r;
    walk_kind_nxt   = walk_kind_r;
    req_dest_nxt    = req_dest_r;
    cmd_pop         = 1'b0;
    emit            = 1'b0;
    emit_res        = '{kind: KIND_ENTER, dest: cfg.my_node, req_clock: '0, last: 1'b1};

    case (state_r)
      ENG_IDLE: begin
        if (cmd_avail && out_free) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            OP_REQ: begin
              if (cmd.stamp_next > local_clock_r) local_clock_nxt = cmd.stamp_next;
              if (inside_r || ((own_stamp_r != '0) && !theirs_first)) begin
                defer_nxt = defer_r | sbit;
                if ((defer_r & sbit) == '0) defer_cnt_nxt = CNT_W'(defer_cnt_r + 1'b1);
              end else begin
                emit     = 1'b1;
                emit_res = '{kind: KIND_PERM, dest: NODE_W'(cmd.sender), req_clock: '0,
                             last: (own_stamp_r == '0)};
                need_nxt = need_r | sbit;
                if ((need_r & sbit) == '0) need_cnt_nxt = CNT_W'(need_cnt_r + 1'b1);
                if (own_stamp_r != '0) begin
                  req_dest_nxt = cmd.sender;
                  state_nxt    = ENG_REQ2;
                end
              end
            end
            OP_PERM: begin
              if (!may_wish_r && !inside_r) begin
                grant_nxt = grant_inc;
                if (grant_inc == GRANT_W'(need_cnt_r)) begin
                  inside_nxt = 1'b1;
                  emit       = 1'b1;
                end
              end
            end
            OP_WISH: begin
              if (may_wish_r && !inside_r) begin
                may_wish_nxt = 1'b0;
                if (need_cnt_r == '0) begin
                  inside_nxt = 1'b1;
                  emit       = 1'b1;
                end else begin
                  own_stamp_nxt = local_clock_r;
                  grant_nxt     = '0;
                  walk_set_nxt  = need_r;
                  walk_idx_nxt  = '0;
                  walk_kind_nxt = KIND_REQ;
                  state_nxt     = ENG_WALK;
                end
              end
            end
            OP_EXIT: begin
              if (inside_r) begin
                own_stamp_nxt = '0;
                need_nxt      = defer_r;
                need_cnt_nxt  = defer_cnt_r;
                defer_nxt     = '0;
                defer_cnt_nxt = '0;
                may_wish_nxt  = 1'b1;
                inside_nxt    = 1'b0;
                if (defer_cnt_r != '0) begin
                  walk_set_nxt  = defer_r;
                  walk_idx_nxt  = '0;
                  walk_kind_nxt = KIND_PERM;
                  state_nxt     = ENG_WALK;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ENG_WALK: begin
        if (walk_set_r[walk_idx_r]) begin
          if (out_free) begin
            emit         = 1'b1;
            emit_res     = '{kind: walk_kind_r, dest: NODE_W'(walk_idx_r),
                             req_clock: (walk_kind_r == KIND_REQ) ? own_stamp_r : '0,
                             last: (walk_rest == '0)};
            walk_set_nxt = walk_rest;
            walk_idx_nxt = IDX_W'(walk_idx_r + 1'b1);
            if (walk_rest == '0) state_nxt = ENG_IDLE;
          end
        end else begin
          walk_idx_nxt = IDX_W'(walk_idx_r + 1'b1);
        end
      end
      ENG_REQ2: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_res  = '{kind: KIND_REQ, dest: NODE_W'(req_dest_r), req_clock: own_stamp_r,
                        last: 1'b1};
          state_nxt = ENG_IDLE;
        end
      end
      default: state_nxt = ENG_IDLE;
    endcase

    // A register write rebuilds the need set; the user must write only when idle, the engine does not enforce it.
    if (cfg.rebuild) begin
      need_nxt     = need_mask(cfg.my_node, cfg.node_count);
      need_cnt_nxt = need_members(cfg.my_node, cfg.node_count);
    end

    out_valid_nxt = out_valid_r && !res_pop;
    out_nxt       = out_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_nxt       = emit_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ENG_IDLE;
      local_clock_r <= STAMP_W'(1);
      own_stamp_r   <= '0;
      grant_r       <= '0;
      need_r        <= need_mask(MY_NODE_RESET, NODE_COUNT_RESET);
      need_cnt_r    <= need_members(MY_NODE_RESET, NODE_COUNT_RESET);
      defer_r       <= '0;
      defer_cnt_r   <= '0;
      may_wish_r    <= 1'b1;
      inside_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      local_clock_r <= local_clock_nxt;
      own_stamp_r   <= own_stamp_nxt;
      grant_r       <= grant_nxt;
      need_r        <= need_nxt;
      need_cnt_r    <= need_cnt_nxt;
      defer_r       <= defer_nxt;
      defer_cnt_r   <= defer_cnt_nxt;
      may_wish_r    <= may_wish_nxt;
      inside_r      <= inside_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    walk_set_r  <= walk_set_nxt;
    walk_idx_r  <= walk_idx_nxt;
    walk_kind_r <= walk_kind_nxt;
    req_dest_r  <= req_dest_nxt;
    out_r       <= out_nxt;
  end

  assign res_valid = out_valid_r;
  assign res       = out_r;

endmodule

@@ rtl/mutual_exclusion_node.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mutual_exclusion_node: one node of permission-reusing mutual exclusion
// Turns received requests, permissions, wishes and exits into outgoing
// request and permission words and an enter signal.
// ----------------------------------------------------------------------------
// Usage:
//   Events enter through a queue-style port: a word is taken at a clock edge
//   where in_push is high and in_full is low. Result words leave the same
//   way: the oldest word sits on the out_ ports while out_empty is low and is
//   taken when out_pop is high. out_last marks the final word of an event.
//   Configuration words (cfg_index 0 own node number, 1 node count) are taken
//   whenever cfg_valid is high; cfg_ready is always high. Write only while
//   the node is quiet.
// Timing:
//   A single-word result reaches the out_ ports through the event queue and
//   then the engine's output register. A wish or exit walks the node bitmap
//   one node per cycle up to the highest set bit, holding on a set bit while
//   the output register is full, and sends one word per set bit. A request
//   granted while this node is itself requesting sends a permission word and
//   then a request word. The bitmap walk sets the sustained rate.
// Reset and stalls:
//   Reset clears both queues and restores the clock, sets and configuration.
//   When the receiver holds off, the engine stalls on its output register,
//   while the four-entry event queue keeps taking words until it fills.
// ----------------------------------------------------------------------------
module mutual_exclusion_node (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [1:0]                     in_op,
  input  logic [mxn_pkg::NODE_W-1:0]     in_sender,
  input  logic [mxn_pkg::STAMP_W-1:0]    in_stamp,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [1:0]                     out_kind,
  output logic [mxn_pkg::NODE_W-1:0]     out_dest,
  output logic [mxn_pkg::STAMP_W-1:0]    out_req_clock,
  output logic                           out_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mxn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mxn_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mxn_pkg::*;

  cfg_t cfg;
  cmd_t push_cmd, head_cmd;
  res_t res;
  logic q_push, q_full, q_pop, q_empty, res_valid;

  // Intake: configuration registers and dropping of events that never act.
  mxn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_op     (in_op),
    .in_sender (in_sender),
    .in_stamp  (in_stamp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd),
    .cfg       (cfg)
  );

  // The queue lets intake keep going while the engine walks a bitmap.
  mxn_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (head_cmd),
    .empty    (q_empty)
  );

  // The engine owns all protocol state and the output register.
  mxn_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd_avail (!q_empty),
    .cmd       (head_cmd),
    .cmd_pop   (q_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_pop   (out_pop)
  );

  assign out_empty     = !res_valid;
  assign out_kind      = res.kind;
  assign out_dest      = res.dest;
  assign out_req_clock = res.req_clock;
  assign out_last      = res.last;

endmodule

@@ rtl/mxn_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mxn_checker: port-level checks of the mutual exclusion node
// Watches the top-level ports and is bound to every instance.
// ----------------------------------------------------------------------------
module mxn_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_empty,
  input logic                        out_pop,
  input logic [1:0]                  out_kind,
  input logic [mxn_pkg::NODE_W-1:0]  out_dest,
  input logic [mxn_pkg::STAMP_W-1:0] out_req_clock,
  input logic                        out_last
);
  import mxn_pkg::*;

  // Nothing is waiting right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result waiting after reset");

  // A waiting word holds until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_kind) && $stable(out_dest) &&
                                  $stable(out_req_clock) && $stable(out_last)))
    else $error("waiting result changed before pop");

  // Enter is always the only and last word of its event, with no stamp.
  a_enter_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind == KIND_ENTER) |-> (out_last && out_req_clock == '0))
    else $error("enter word malformed");

  // Permission words carry no stamp; request words always carry one.
  a_stamp: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> ((out_kind == KIND_PERM && out_req_clock == '0) ||
                    (out_kind == KIND_REQ && out_req_clock != '0) ||
                    out_kind == KIND_ENTER))
    else $error("result stamp or kind inconsistent");

endmodule

bind mutual_exclusion_node mxn_checker u_mxn_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_empty     (out_empty),
  .out_pop       (out_pop),
  .out_kind      (out_kind),
  .out_dest      (out_dest),
  .out_req_clock (out_req_clock),
  .out_last      (out_last)
);

@@ sim/tb_mutual_exclusion_node.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mutual_exclusion_node: self-checking bench for one mutual exclusion node
// Feeds request, permission, wish and exit words through the input queue,
// predicts every outgoing word with a behavioral copy of the node, and checks
// the popped words field by field under several configurations and paces.
// ----------------------------------------------------------------------------
module tb_mutual_exclusion_node;
  import mxn_pkg::*;

  localparam int     HALF_NS       = 6;
  localparam int     RESET_CYCLES  = 6;
  // A wish or exit walks the whole bitmap, and up to four events can sit in
  // the input queue, so this covers every word that can still be in flight.
  localparam int     SETTLE_CYCLES = 8 * NODES + 32;
  localparam longint TIMEOUT_NS    = 64'd4_000_000;
  localparam int     PHASES        = 7;
  localparam int     MAX_PRINTS    = 50;

  // One event word as the node sees it.
  typedef struct {
    op_t                op;
    logic [NODE_W-1:0]  sender;
    logic [STAMP_W-1:0] stamp;
  } node_evt_t;

  // One outgoing word as the node produces it.
  typedef struct {
    kind_t              kind;
    logic [NODE_W-1:0]  dest;
    logic [STAMP_W-1:0] req_clock;
    logic               last;
  } node_word_t;

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  in_push       = 1'b0;
  logic                  in_full;
  logic [1:0]            in_op         = '0;
  logic [NODE_W-1:0]     in_sender     = '0;
  logic [STAMP_W-1:0]    in_stamp      = '0;
  logic                  out_empty;
  logic                  out_pop       = 1'b0;
  logic [1:0]            out_kind;
  logic [NODE_W-1:0]     out_dest;
  logic [STAMP_W-1:0]    out_req_clock;
  logic                  out_last;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;

  mutual_exclusion_node u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_op         (in_op),
    .in_sender     (in_sender),
    .in_stamp      (in_stamp),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_kind      (out_kind),
    .out_dest      (out_dest),
    .out_req_clock (out_req_clock),
    .out_last      (out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #(HALF_NS) clk = 1'b1;
    #(HALF_NS) clk = 1'b0;
  end

  // Words waiting to be pushed, and words the node still owes us.
  node_evt_t  events_to_send[$];
  node_word_t words_due[$];
  int         mismatches    = 0;
  int         events_queued = 0;

  // Pace of both sides, in percent of cycles spent idle or stalled.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Center of the stamp band used by random requests. Keeping incoming stamps
  // close to the node's own clock gives a fair mix of earlier and later
  // requests, so both the defer path and the grant path get exercised.
  logic [STAMP_W-1:0] stamp_base = 32'd40;

  // --------------------------------------------------------------------------
  // Behavioral copy of the node: configuration and protocol state.
  // --------------------------------------------------------------------------
  logic [NODE_W-1:0]   cfg_me     = MY_NODE_RESET;
  logic [NCOUNT_W-1:0] cfg_count  = NODE_COUNT_RESET;
  logic [STAMP_W-1:0]  lamport    = 32'd1;
  logic [STAMP_W-1:0]  my_stamp   = '0;
  logic [GRANT_W-1:0]  grants     = '0;
  logic [NODES-1:0]    need_bits  = '0;
  logic [NODES-1:0]    defer_bits = '0;
  logic                can_wish   = 1'b1;
  logic                in_cs      = 1'b0;

  // Every node below the clamped count, except ourselves, must grant us.
  function automatic void refresh_need();
    int span;
    span = (int'(cfg_count) > NODES) ? NODES : int'(cfg_count);
    if (span == 0) span = 1;
    need_bits = '0;
    for (int i = 0; i < span; i++) begin
      if (i != int'(cfg_me)) need_bits[i] = 1'b1;
    end
  endfunction

  function automatic node_word_t make_word(input kind_t k, input logic [NODE_W-1:0] d,
                                           input logic [STAMP_W-1:0] c);
    node_word_t w;
    w.kind      = k;
    w.dest      = d;
    w.req_clock = c;
    w.last      = 1'b0;
    return w;
  endfunction

  // Applies one accepted event to the copy and queues the words it causes,
  // in ascending node order, with the last flag on the final one.
  task automatic step_node(input node_evt_t ev);
    node_word_t         outq[$];
    node_word_t         w;
    logic [STAMP_W-1:0] next_clock;
    logic               theirs_first;
    // A node number outside the ring silences the node completely.
    if (int'(cfg_me) >= NODES) return;
    case (ev.op)
      OP_REQ: begin
        // Requests from ourselves or from outside the ring are dropped
        // before they can touch the clock.
        if (int'(ev.sender) < NODES && ev.sender != cfg_me) begin
          next_clock = (ev.stamp == CLOCK_MAX) ? CLOCK_MAX : ev.stamp + 1'b1;
          if (next_clock > lamport) lamport = next_clock;
          theirs_first = (ev.stamp < my_stamp) ||
                         (ev.stamp == my_stamp && ev.sender < cfg_me);
          if (in_cs || (my_stamp != '0 && !theirs_first)) begin
            defer_bits[ev.sender] = 1'b1;
          end else begin
            // Granting hands our permission away, so we must ask again.
            outq.push_back(make_word(KIND_PERM, ev.sender, '0));
            need_bits[ev.sender] = 1'b1;
            if (my_stamp != '0) outq.push_back(make_word(KIND_REQ, ev.sender, my_stamp));
          end
        end
      end
      OP_PERM: begin
        // Only counted while waiting; stray permissions are dropped.
        if (!can_wish && !in_cs) begin
          if (grants != GRANT_MAX) grants = grants + 1'b1;
          if (int'(grants) == $countones(need_bits)) begin
            in_cs = 1'b1;
            outq.push_back(make_word(KIND_ENTER, cfg_me, '0));
          end
        end
      end
      OP_WISH: begin
        if (can_wish && !in_cs) begin
          can_wish = 1'b0;
          if (need_bits == '0) begin
            // Every permission is still held from earlier rounds.
            in_cs = 1'b1;
            outq.push_back(make_word(KIND_ENTER, cfg_me, '0));
          end else begin
            for (int i = 0; i < NODES; i++) begin
              if (need_bits[i]) outq.push_back(make_word(KIND_REQ, NODE_W'(i), lamport));
            end
            my_stamp = lamport;
            grants   = '0;
          end
        end
      end
      OP_EXIT: begin
        if (in_cs) begin
          for (int i = 0; i < NODES; i++) begin
            if (defer_bits[i]) outq.push_back(make_word(KIND_PERM, NODE_W'(i), '0));
          end
          my_stamp   = '0;
          need_bits  = defer_bits;
          defer_bits = '0;
          can_wish   = 1'b1;
          in_cs      = 1'b0;
        end
      end
      default: ;
    endcase
    foreach (outq[k]) begin
      w      = outq[k];
      w.last = (k == outq.size() - 1);
      words_due.push_back(w);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < MAX_PRINTS) begin
      $display("%0t ns: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Driver. The posedge half notes which word the node took and runs the
  // prediction for it; the negedge half offers the next word or idles.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_push && !in_full && events_to_send.size() != 0) begin
      step_node(events_to_send[0]);
      void'(events_to_send.pop_front());
    end
  end

  always @(negedge clk) begin
    if (rst_n && events_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      in_push   <= 1'b1;
      in_op     <= events_to_send[0].op;
      in_sender <= events_to_send[0].sender;
      in_stamp  <= events_to_send[0].stamp;
    end else begin
      in_push <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. The receiver stalls at random; every popped word is compared
  // with the oldest word still owed.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    out_pop <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    node_word_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (words_due.size() == 0) begin
        report_mismatch("unexpected word (kind,dest)", {out_kind, out_dest}, '0);
      end else begin
        want = words_due.pop_front();
        if (out_kind !== want.kind) report_mismatch("kind", out_kind, want.kind);
        if (out_dest !== want.dest) report_mismatch("dest", out_dest, want.dest);
        if (out_req_clock !== want.req_clock) begin
          report_mismatch("req_clock", out_req_clock, want.req_clock);
        end
        if (out_last !== want.last) report_mismatch("last", out_last, want.last);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  function automatic void queue_evt(input op_t op, input logic [NODE_W-1:0] sender,
                                    input logic [STAMP_W-1:0] stamp);
    node_evt_t ev;
    ev.op     = op;
    ev.sender = sender;
    ev.stamp  = stamp;
    events_to_send.push_back(ev);
    events_queued++;
  endfunction

  // Mostly a node inside the ring; now and then anything, out-of-ring ones too.
  function automatic logic [NODE_W-1:0] pick_sender(input int span);
    if ($urandom_range(99) < 15) return NODE_W'($urandom_range(63));
    return NODE_W'($urandom_range(span - 1));
  endfunction

  function automatic logic [STAMP_W-1:0] pick_stamp();
    return stamp_base + STAMP_W'($urandom_range(24)) - 32'd12;
  endfunction

  // One round of the protocol: a few early requests, the wish, enough
  // permissions to get in with requests mixed among them, then the exit.
  // Some rounds carry noise or leave out the exit.
  function automatic void add_round(input int span);
    int grants_to_send;
    repeat ($urandom_range(2)) queue_evt(OP_REQ, pick_sender(span), pick_stamp());
    queue_evt(OP_WISH, NODE_W'($urandom_range(63)), pick_stamp());
    grants_to_send = span - 1 + $urandom_range(2);
    for (int g = 0; g < grants_to_send; g++) begin
      queue_evt(OP_PERM, NODE_W'($urandom_range(63)), pick_stamp());
      if ($urandom_range(3) == 0) queue_evt(OP_REQ, pick_sender(span), pick_stamp());
    end
    if ($urandom_range(2) == 0) queue_evt(OP_REQ, pick_sender(span), pick_stamp());
    if ($urandom_range(9) == 0) begin
      // A request from outside the ring is dropped whole, so a wild stamp
      // here toggles every stamp bit without dragging the clock along.
      queue_evt(OP_REQ, NODE_W'($urandom_range(63, NODES)), $urandom | 32'd1);
    end
    if ($urandom_range(9) == 0) begin
      queue_evt(op_t'($urandom_range(3)), NODE_W'($urandom_range(63)), pick_stamp());
    end
    if ($urandom_range(9) != 0) queue_evt(OP_EXIT, NODE_W'($urandom_range(63)), pick_stamp());
    stamp_base = stamp_base + STAMP_W'($urandom_range(16, 4));
  endfunction

  task automatic set_pace(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Waits until every word was taken and every owed word came back, then
  // gives the engine time to finish anything that produces no word.
  task automatic settle();
    while (events_to_send.size() != 0 || words_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Brings the node back to idle by feeding permissions while it waits and
  // an exit while it is inside, then settles.
  task automatic close_out();
    logic busy;
    busy = 1'b1;
    while (busy) begin
      while (events_to_send.size() != 0) @(negedge clk);
      if (in_cs) queue_evt(OP_EXIT, '0, 32'd1);
      else if (!can_wish) queue_evt(OP_PERM, '0, 32'd1);
      else busy = 1'b0;
    end
    settle();
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_MY_NODE) cfg_me = NODE_W'(value);
    else cfg_count = NCOUNT_W'(value);
    refresh_need();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  int ph_me    [PHASES] = '{1, 0, 5, 2, 31, 6, 0};
  int ph_count [PHASES] = '{4, 3, 6, 2, 40, 12, 1};
  int ph_send  [PHASES] = '{0, 63, 0, 27, 0, 27, 63};
  int ph_recv  [PHASES] = '{0, 0, 63, 27, 63, 27, 0};
  int ph_target[PHASES] = '{10, 10, 10, 10, 1, 10, 8};

  initial begin
    int span;
    int start;
    refresh_need();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, node 3 in a ring of six, both sides at full speed.
    set_pace(0, 0);
    write_reg(REG_MY_NODE, 3);
    write_reg(REG_NODE_COUNT, 6);
    queue_evt(OP_PERM, 6'd42, 32'd1);            // stray permission
    queue_evt(OP_EXIT, 6'd17, 32'd1);            // exit while outside
    queue_evt(OP_REQ, 6'd3, 32'd10);             // request from ourselves
    queue_evt(OP_REQ, 6'd63, 32'd10);            // sender outside the ring
    queue_evt(OP_REQ, 6'd0, 32'd20);             // granted, clock moves to 21
    queue_evt(OP_REQ, 6'd31, 32'd1);             // granted, top node joins need
    queue_evt(OP_WISH, 6'd0, 32'd1);             // requests out with stamp 21
    queue_evt(OP_WISH, 6'd0, 32'd1);             // wish while waiting
    queue_evt(OP_REQ, 6'd1, 32'd21);             // equal stamp, lower node wins
    queue_evt(OP_REQ, 6'd4, 32'd21);             // equal stamp, higher node waits
    queue_evt(OP_REQ, 6'd0, 32'd5);              // earlier stamp wins
    queue_evt(OP_REQ, 6'd5, 32'd30);             // later stamp waits
    repeat (6) queue_evt(OP_PERM, 6'd9, 32'd1);  // the sixth one lets us in
    queue_evt(OP_REQ, 6'd2, 32'd7);              // inside, so deferred
    queue_evt(OP_EXIT, 6'd0, 32'd1);             // grants to 2, 4 and 5
    settle();

    // Alone in the ring: the wish enters at once, the exit sends nothing.
    write_reg(REG_MY_NODE, 0);
    write_reg(REG_NODE_COUNT, 1);
    queue_evt(OP_WISH, 6'd0, 32'd1);
    queue_evt(OP_EXIT, 6'd0, 32'd1);
    settle();

    // Own number outside the ring: everything is dropped.
    write_reg(REG_MY_NODE, 63);
    queue_evt(OP_REQ, 6'd1, 32'd9);
    queue_evt(OP_WISH, 6'd0, 32'd1);
    settle();

    // Widest ring: one wish asks every other node at once.
    write_reg(REG_MY_NODE, 0);
    write_reg(REG_NODE_COUNT, 64);
    queue_evt(OP_WISH, 6'd0, 32'd1);
    close_out();

    // Random part, one phase per configuration and pace.
    for (int p = 0; p < PHASES; p++) begin
      close_out();
      write_reg(REG_MY_NODE, ph_me[p]);
      write_reg(REG_NODE_COUNT, ph_count[p]);
      set_pace(ph_send[p], ph_recv[p]);
      span = (ph_count[p] > NODES) ? NODES : ph_count[p];
      // The wide phase also lifts the stamps high into the word.
      if (span == NODES) stamp_base = 32'hC000_0000 + $urandom_range(1000);
      start = events_queued;
      while (events_queued - start < ph_target[p]) add_round(span);
    end
    close_out();

    // Clock saturation last, since the clock never comes back down from it.
    set_pace(27, 27);
    write_reg(REG_MY_NODE, 3);
    write_reg(REG_NODE_COUNT, 6);
    queue_evt(OP_REQ, 6'd0, CLOCK_MAX);          // clock sticks at the top
    queue_evt(OP_WISH, 6'd0, 32'd1);             // requests carry the top stamp
    queue_evt(OP_REQ, 6'd1, CLOCK_MAX);          // tie at the top, lower node wins
    queue_evt(OP_REQ, 6'd4, CLOCK_MAX);          // tie at the top, higher node waits
    close_out();

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Safety net in case the node stops answering.
  initial begin
    #(TIMEOUT_NS);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
